@@ rtl/rk3o_pkg.sv @@
// Shared widths, register indexes and defaults for the driven oscillator stepper.
package rk3o_pkg;

  localparam int DATA_W        = 32;
  localparam int STEP_W        = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL     = 4'd7;

  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd655;
  localparam logic [DATA_W-1:0] STIFFNESS_RST = 32'd258725761;
  localparam logic [DATA_W-1:0] INIT_POS_RST  = 32'd65536;

endpackage

@@ rtl/rk3o_in_if.sv @@
// Input channel: one restart-or-step request per beat.
interface rk3o_in_if ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/rk3o_out_if.sv @@
// Result channel: oscillator state after each item.
interface rk3o_out_if import rk3o_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] position_out;
  logic [DATA_W-1:0] velocity_out;
  logic [DATA_W-1:0] step_index;
  logic              saturated;
  modport source (output valid, output position_out, output velocity_out, output step_index,
                  output saturated, input ready);
  modport sink (input valid, input position_out, input velocity_out, input step_index,
                input saturated, output ready);
endinterface

@@ rtl/rk3o_cfg_if.sv @@
// Configuration write channel: register index and data per beat.
interface rk3o_cfg_if import rk3o_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/rk3o_mul.sv @@
// Shared signed 33 by 33 multiplier with a registered product.
module rk3o_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

@@ rtl/rk3o_sine.sv @@
// Quarter-wave sine table in Q1.15 with quadrant folding and a registered output.
module rk3o_sine #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic [31:0]        angle,
  output logic signed [16:0] sin_r
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = 31 + IW;

  logic [14:0]   rom [SINE_TABLE_DEPTH];
  logic [PW-1:0] iprod;
  logic [IW:0]   idx_raw;
  logic [IW-1:0] idx;
  logic [14:0]   mag;

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned U  = (64'(2 * gi + 1) << 30) / (2 * SINE_TABLE_DEPTH);
    localparam longint unsigned U2 = (U * U) >> 30;
    localparam longint unsigned T  = 64'd693598668 - ((U2 * 64'd80710779) >> 30);
    localparam longint unsigned S  = 64'd1686629713 - ((U2 * T) >> 30);
    localparam longint unsigned Q  = (U * S) >> 30;
    localparam longint unsigned R  = (Q * 64'd32767 + (64'd1 << 29)) >> 30;
    assign rom[gi] = (R > 64'd32767) ? 15'd32767 : 15'(R);
  end

  always_comb begin
    iprod   = PW'(angle[29:0]) * PW'(SINE_TABLE_DEPTH);
    idx_raw = iprod[PW-1:30];
    if (idx_raw >= (IW+1)'(SINE_TABLE_DEPTH)) begin
      idx = IW'(SINE_TABLE_DEPTH - 1);
    end else begin
      idx = idx_raw[IW-1:0];
    end
    if (angle[30]) begin
      idx = IW'(SINE_TABLE_DEPTH - 1) - idx;
    end
    mag = rom[idx];
  end

  always_ff @(posedge clk) begin
    sin_r <= angle[31] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  end

endmodule

@@ rtl/rk3o_div6.sv @@
// Signed division by six, truncating toward zero, by a registered halving and a registered reciprocal multiply.
module rk3o_div6 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [35:0] dividend,
  output logic               done_r,
  output logic signed [35:0] quotient
);

  // The halved magnitude is at most 1.5 * 2^32, so ceil(2^34 / 3) gives exact thirds.
  localparam logic [32:0] RECIP3 = 33'd5726623062;

  logic        busy_r;
  logic        neg_r;
  logic [32:0] half_r;
  logic [31:0] mq_r;
  logic [35:0] mag;
  logic [65:0] prod;

  always_comb begin
    mag  = dividend[35] ? 36'(-dividend) : 36'(dividend);
    prod = 66'(half_r) * 66'(RECIP3);
  end

  assign quotient = neg_r ? -$signed({4'd0, mq_r}) : $signed({4'd0, mq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
      if (start) begin
        neg_r  <= dividend[35];
        half_r <= mag[33:1];
      end
      if (busy_r) begin
        mq_r <= prod[65:34];
      end
    end
  end

endmodule

@@ rtl/driven_oscillator_rk3_step.sv @@
// Top level: third-order Runge-Kutta stepper for a damped, driven oscillator.
//
// Each beat on in_ch either restarts the oscillator from the configured
// initial position and velocity or advances it by one step of size h.
// Every accepted beat yields exactly one beat on out_ch carrying position,
// velocity, steps since restart and a flag that is set when any value of
// the step was clipped to the signed 32-bit range.
// A step runs three derivative evaluations on one shared multiplier, five
// products per evaluation, each through a multiply and an accumulate state,
// with a sine table read before and a combine state after each evaluation,
// followed by a division by six through a reciprocal multiply. A restart
// skips the evaluations and goes straight to the output stage.
// in_ch.ready is high only while the block is idle; one item is in work at
// a time. A finished result waits in the output register; if out_ch stalls,
// the next item is accepted and runs, and holds at its end until the
// output register is free.
// Configuration writes on cfg_ch are always accepted and belong in idle
// periods. Reset loads the register defaults and the state x=1.0, v=0.
module driven_oscillator_rk3_step import rk3o_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rk3o_in_if.sink   in_ch,
  rk3o_out_if.source out_ch,
  rk3o_cfg_if.sink  cfg_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SINE = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_COMB = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_HV     = 3'd0,
    OP_DRIVE  = 3'd1,
    OP_SPRING = 3'd2,
    OP_FRIC   = 3'd3,
    OP_HA     = 3'd4
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  state_t state_r;
  op_t    op_r;
  logic [1:0] stg_r;

  logic [STEP_W-1:0]        step_r;
  logic [DATA_W-1:0]        stiff_r, damp_r, pstep_r, poff_r;
  logic signed [DATA_W-1:0] amp_r, ipos_r, ivel_r;

  logic signed [31:0] pos_r, vel_r, xs_r, vs_r, a_r;
  logic [31:0]        phase_r, cph_r, count_r;
  logic signed [31:0] kx_r [3];
  logic signed [31:0] kv_r [3];
  logic signed [63:0] acc_r;
  logic               clip_r;

  logic               out_valid_r, out_sat_r;
  logic [31:0]        out_pos_r, out_vel_r, out_cnt_r;

  logic signed [16:0] sin_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [65:0] shifted;
  logic signed [63:0] term, acc_d;
  logic               div_start, div_done, div_done_x, div_done_v;
  logic signed [35:0] sum_x, sum_v, q_x, q_v;
  logic signed [63:0] x2, v2, x3, v3, xf, vf;

  rk3o_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk   (clk),
    .angle (cph_r + poff_r),
    .sin_r (sin_r)
  );

  rk3o_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  rk3o_div6 u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_x),
    .done_r   (div_done_x),
    .quotient (q_x)
  );

  rk3o_div6 u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_v),
    .done_r   (div_done_v),
    .quotient (q_v)
  );

  assign div_done = div_done_x && div_done_v;

  always_comb begin
    mul_a = $signed({17'd0, step_r});
    mul_b = 33'(vs_r);
    unique case (op_r)
      OP_HV: begin
        mul_a = $signed({17'd0, step_r});
        mul_b = 33'(vs_r);
      end
      OP_DRIVE: begin
        mul_a = 33'(amp_r);
        mul_b = 33'(sin_r);
      end
      OP_SPRING: begin
        mul_a = $signed({1'b0, stiff_r});
        mul_b = 33'(xs_r);
      end
      OP_FRIC: begin
        mul_a = $signed({1'b0, damp_r});
        mul_b = 33'(vs_r);
      end
      OP_HA: begin
        mul_a = $signed({17'd0, step_r});
        mul_b = 33'(a_r);
      end
      default: begin
        mul_a = $signed({17'd0, step_r});
        mul_b = 33'(vs_r);
      end
    endcase
  end

  always_comb begin
    case (op_r) inside
      OP_DRIVE:           shifted = prod_r >>> 15;
      OP_SPRING, OP_FRIC: shifted = prod_r >>> FRAC_BITS;
      default:            shifted = prod_r >>> 16;
    endcase
    term  = shifted[63:0];
    acc_d = acc_r - term;
    x2    = 64'(pos_r) + (64'(kx_r[0]) >>> 1);
    v2    = 64'(vel_r) + (64'(kv_r[0]) >>> 1);
    x3    = 64'(pos_r) + (64'(kx_r[1]) <<< 1) - 64'(kx_r[0]);
    v3    = 64'(vel_r) + (64'(kv_r[1]) <<< 1) - 64'(kv_r[0]);
    sum_x = 36'(kx_r[0]) + (36'(kx_r[1]) <<< 2) + 36'(kx_r[2]);
    sum_v = 36'(kv_r[0]) + (36'(kv_r[1]) <<< 2) + 36'(kv_r[2]);
    xf    = 64'(pos_r) + 64'(q_x);
    vf    = 64'(vel_r) + 64'(q_v);
  end

  assign div_start = (state_r == S_COMB) && (stg_r == 2'd2);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.position_out = out_pos_r;
  assign out_ch.velocity_out = out_vel_r;
  assign out_ch.step_index   = out_cnt_r;
  assign out_ch.saturated    = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_SIZE_RST;
      stiff_r <= STIFFNESS_RST;
      damp_r  <= '0;
      amp_r   <= '0;
      pstep_r <= '0;
      poff_r  <= '0;
      ipos_r  <= INIT_POS_RST;
      ivel_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEP_SIZE:    step_r  <= cfg_ch.data[STEP_W-1:0];
        REG_STIFFNESS:    stiff_r <= cfg_ch.data;
        REG_DAMPING:      damp_r  <= cfg_ch.data;
        REG_DRIVE_AMP:    amp_r   <= cfg_ch.data;
        REG_PHASE_STEP:   pstep_r <= cfg_ch.data;
        REG_PHASE_OFFSET: poff_r  <= cfg_ch.data;
        REG_INIT_POS:     ipos_r  <= cfg_ch.data;
        REG_INIT_VEL:     ivel_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_HV;
      stg_r       <= 2'd0;
      out_valid_r <= 1'b0;
      pos_r       <= INIT_POS_RST;
      vel_r       <= '0;
      phase_r     <= '0;
      count_r     <= '0;
      clip_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            clip_r <= 1'b0;
            if (in_ch.restart) begin
              pos_r   <= ipos_r;
              vel_r   <= ivel_r;
              phase_r <= '0;
              count_r <= '0;
              state_r <= S_FIN;
            end else begin
              xs_r    <= pos_r;
              vs_r    <= vel_r;
              cph_r   <= phase_r;
              stg_r   <= 2'd0;
              state_r <= S_SINE;
            end
          end
        end
        S_SINE: begin
          op_r    <= OP_HV;
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_MUL;
          unique case (op_r)
            OP_HV: begin
              kx_r[stg_r] <= term[31:0];
              op_r        <= OP_DRIVE;
            end
            OP_DRIVE: begin
              acc_r <= term;
              op_r  <= OP_SPRING;
            end
            OP_SPRING: begin
              acc_r <= acc_d;
              op_r  <= OP_FRIC;
            end
            OP_FRIC: begin
              a_r    <= sat32(acc_d);
              clip_r <= clip_r | ovf32(acc_d);
              op_r   <= OP_HA;
            end
            OP_HA: begin
              kv_r[stg_r] <= term[31:0];
              state_r     <= S_COMB;
            end
            default: begin
              op_r <= OP_HV;
            end
          endcase
        end
        S_COMB: begin
          if (stg_r == 2'd0) begin
            xs_r    <= sat32(x2);
            vs_r    <= sat32(v2);
            clip_r  <= clip_r | ovf32(x2) | ovf32(v2);
            cph_r   <= cph_r + pstep_r;
            stg_r   <= 2'd1;
            state_r <= S_SINE;
          end else if (stg_r == 2'd1) begin
            xs_r    <= sat32(x3);
            vs_r    <= sat32(v3);
            clip_r  <= clip_r | ovf32(x3) | ovf32(v3);
            cph_r   <= cph_r + pstep_r;
            stg_r   <= 2'd2;
            state_r <= S_SINE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos_r   <= sat32(xf);
            vel_r   <= sat32(vf);
            clip_r  <= clip_r | ovf32(xf) | ovf32(vf);
            phase_r <= cph_r;
            count_r <= count_r + 32'd1;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= pos_r;
            out_vel_r   <= vel_r;
            out_cnt_r   <= count_r;
            out_sat_r   <= clip_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb_driven_oscillator_rk3_step.sv @@
// Testbench for the driven oscillator RK3 stepper: directed and random steps checked per beat.
`timescale 1ns / 100ps

module tb_driven_oscillator_rk3_step;
  import rk3o_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int QFRAC = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] steps;
    logic        clipped;
  } osc_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rk3o_in_if  in_ch ();
  rk3o_out_if out_ch ();
  rk3o_cfg_if cfg_ch ();

  driven_oscillator_rk3_step u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  longint sine_table [TABLE_DEPTH];
  longint h_reg, k_reg, c_reg, amp_reg, dphi_reg, phi_reg, x0_reg, v0_reg;
  longint pos_m, vel_m;
  logic [31:0] phase_m, count_m;

  osc_state_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int restarts_sent = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit allow_gaps = 1'b1;
  bit hold_off = 1'b0;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip32(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic build_table();
    longint unsigned u, u2, t, s, q, r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      u = ((64'd2 * i + 1) << 30) / (64'd2 * TABLE_DEPTH);
      u2 = (u * u) >> 30;
      t = 64'd693598668 - ((u2 * 64'd80710779) >> 30);
      s = 64'd1686629713 - ((u2 * t) >> 30);
      q = (u * s) >> 30;
      r = (q * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 32767) r = 32767;
      sine_table[i] = longint'(r);
    end
  endtask

  function automatic longint sine_q15(logic [31:0] angle);
    longint unsigned frac;
    int idx;
    frac = angle[29:0];
    idx = int'((frac * TABLE_DEPTH) >> 30);
    if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
    if (angle[30]) idx = TABLE_DEPTH - 1 - idx;
    return angle[31] ? -sine_table[idx] : sine_table[idx];
  endfunction

  function automatic longint accel(logic [31:0] ph, longint x, longint v, ref bit clip);
    logic [31:0] a;
    a = ph + phi_reg[31:0];
    return clip32(asr(amp_reg * sine_q15(a), 15) - asr(k_reg * x, QFRAC)
                  - asr(c_reg * v, QFRAC), clip);
  endfunction

  function automatic longint hmul(longint v);
    return asr(v * h_reg, 16);
  endfunction

  function automatic osc_state_t advance_oscillator(bit restart);
    bit clip;
    logic [31:0] p2, p3;
    longint kx1, kv1, kx2, kv2, kx3, kv3, x2, v2, x3, v3;
    osc_state_t r;
    clip = 1'b0;
    if (restart) begin
      pos_m = x0_reg;
      vel_m = v0_reg;
      phase_m = '0;
      count_m = '0;
    end else begin
      p2 = phase_m + dphi_reg[31:0];
      p3 = p2 + dphi_reg[31:0];
      kx1 = hmul(vel_m);
      kv1 = hmul(accel(phase_m, pos_m, vel_m, clip));
      x2 = clip32(pos_m + asr(kx1, 1), clip);
      v2 = clip32(vel_m + asr(kv1, 1), clip);
      kx2 = hmul(v2);
      kv2 = hmul(accel(p2, x2, v2, clip));
      x3 = clip32(pos_m + 2 * kx2 - kx1, clip);
      v3 = clip32(vel_m + 2 * kv2 - kv1, clip);
      kx3 = hmul(v3);
      kv3 = hmul(accel(p3, x3, v3, clip));
      pos_m = clip32(pos_m + (kx1 + 4 * kx2 + kx3) / 6, clip);
      vel_m = clip32(vel_m + (kv1 + 4 * kv2 + kv3) / 6, clip);
      phase_m = p3;
      count_m = count_m + 1;
    end
    r.position = pos_m[31:0];
    r.velocity = vel_m[31:0];
    r.steps = count_m;
    r.clipped = clip;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_STEP_SIZE:    h_reg = value[15:0];
      REG_STIFFNESS:    k_reg = value;
      REG_DAMPING:      c_reg = value;
      REG_DRIVE_AMP:    amp_reg = sext(value);
      REG_PHASE_STEP:   dphi_reg = value;
      REG_PHASE_OFFSET: phi_reg = value;
      REG_INIT_POS:     x0_reg = sext(value);
      REG_INIT_VEL:     v0_reg = sext(value);
      default: ;
    endcase
  endtask

  task automatic send_item(bit restart);
    int gap;
    if (allow_gaps && $urandom_range(3) == 0) begin
      gap = $urandom_range(11, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(advance_oscillator(restart));
    if (restart) restarts_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] h, logic [31:0] k, logic [31:0] c, logic [31:0] a,
                         logic [31:0] dp, logic [31:0] po, logic [31:0] x0, logic [31:0] v0);
    wait_idle();
    write_reg(REG_STEP_SIZE, {16'd0, h});
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_DAMPING, c);
    write_reg(REG_DRIVE_AMP, a);
    write_reg(REG_PHASE_STEP, dp);
    write_reg(REG_PHASE_OFFSET, po);
    write_reg(REG_INIT_POS, x0);
    write_reg(REG_INIT_VEL, v0);
  endtask

  task automatic test_reset_defaults();
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_extremes();
    set_all(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    set_all(16'd0, 32'd0, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    wait_idle();
    write_reg(4'd9, 32'hDEAD_BEEF);
    write_reg(4'd15, 32'h1234_5678);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_backpressure();
    set_all(16'd655, 32'h0004_0000, 32'h0000_4000, 32'h0001_0000, 32'h0100_0000,
            32'h1000_0000, 32'h0001_0000, 32'd0);
    send_item(1'b1);
    hold_off = 1'b1;
    hold_cycles = 400;
    repeat (6) send_item(1'b0);
  endtask

  task automatic test_random(int count, bit gaps);
    allow_gaps = gaps;
    for (int i = 0; i < count; i++) send_item($urandom_range(40) == 0);
  endtask

  task automatic random_settings(int mode);
    logic [15:0] h;
    logic [31:0] k, c, a;
    h = (mode == 0) ? 16'(($urandom_range(2000, 1))) : 16'($urandom);
    k = (mode == 0) ? $urandom_range(32'h0040_0000) : $urandom;
    c = (mode == 0) ? $urandom_range(32'h0002_0000) : $urandom;
    a = (mode == 0) ? 32'(signed'($urandom_range(32'h0008_0000)) - 32'sh0004_0000) : $urandom;
    set_all(h, k, c, a, $urandom, $urandom, $urandom, $urandom);
    send_item(1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles--;
      else hold_off = 1'b0;
    end else if (allow_gaps && $urandom_range(5) == 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    osc_state_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.position_out, out_ch.velocity_out, out_ch.step_index, out_ch.saturated};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%h v=%h n=%0d s=%b, got x=%h v=%h n=%0d s=%b",
                     want.position, want.velocity, want.steps, want.clipped,
                     got.position, got.velocity, got.steps, got.clipped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    build_table();
    h_reg = STEP_SIZE_RST;
    k_reg = STIFFNESS_RST;
    c_reg = 0;
    amp_reg = 0;
    dphi_reg = 0;
    phi_reg = 0;
    x0_reg = sext(INIT_POS_RST);
    v0_reg = 0;
    pos_m = x0_reg;
    vel_m = 0;
    phase_m = '0;
    count_m = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_backpressure();
    for (int p = 0; p < 6; p++) begin
      random_settings(p % 3 == 2);
      test_random(200, 1'b1);
    end
    random_settings(0);
    test_random(200, 1'b0);
    wait_idle();
    $display("Covered %0d result beats with %0d restarts over several register settings,",
             results_seen, restarts_sent);
    $display("including extreme values, saturation and a long output stall.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ driven_oscillator_rk3_step.f @@
rtl/rk3o_pkg.sv
rtl/rk3o_in_if.sv
rtl/rk3o_out_if.sv
rtl/rk3o_cfg_if.sv
rtl/rk3o_mul.sv
rtl/rk3o_sine.sv
rtl/rk3o_div6.sv
rtl/driven_oscillator_rk3_step.sv
verif/tb_driven_oscillator_rk3_step.sv
